// ----- hw/rtl/ritoa_pkg.sv -----
// Shared types, constants and helpers for the radix integer to ASCII converter.
`timescale 1ns / 1ps

package ritoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int IN_VALUE_W      = 32;
  localparam int BASE_W          = 5;
  localparam int CHAR_W          = 7;
  localparam int COUNT_W         = 6;
  localparam int DIGIT_W         = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int OUT_DEPTH       = 2;

  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A_BIAS = 7'h57;  // 'a' minus ten
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [BASE_W-1:0]     base;
    logic                  pad_zero;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic               is_last;
    logic               empty_res;
    logic [COUNT_W-1:0] digit_count;
  } res_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              pad_zero;
    logic              no_digits;
  } job_ctl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_NEXT,
    BK_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A_BIAS + {3'b000, d};
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/ritoa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ritoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ritoa_queue.sv -----
// Short job queue between the front and back parts.
`timescale 1ns / 1ps

module ritoa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ritoa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/ritoa_front.sv -----
// Front part: accepts requests, saturates the base and flags empty conversions.
`timescale 1ns / 1ps

module ritoa_front #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  ritoa_pkg::req_t          req,
  output logic                     q_push,
  input  logic                     q_full,
  output ritoa_pkg::job_ctl_t      job_ctl,
  output logic [VALUE_WIDTH-1:0]   job_value
);

  logic                     fv;
  logic                     accept;
  logic                     advance;
  logic [VALUE_WIDTH-1:0]   masked;
  ritoa_pkg::job_ctl_t      ctl_in;

  assign advance = fv && !q_full;
  assign full    = fv && q_full;
  assign accept  = push && !full;
  assign q_push  = advance;

  always_comb begin
    masked           = VALUE_WIDTH'(req.value);
    ctl_in.pad_zero  = req.pad_zero;
    ctl_in.no_digits = !req.pad_zero && (masked == '0);
    if (req.base < ritoa_pkg::BASE_MIN) begin
      ctl_in.base = ritoa_pkg::BASE_MIN;
    end else if (req.base > ritoa_pkg::BASE_MAX) begin
      ctl_in.base = ritoa_pkg::BASE_MAX;
    end else begin
      ctl_in.base = req.base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (advance) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_ctl   <= ctl_in;
      job_value <= masked;
    end
  end

endmodule

// ----- hw/rtl/ritoa_back.sv -----
// Back part: digit extraction by chunked long division, digit buffer and output queue.
`timescale 1ns / 1ps

module ritoa_back #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  ritoa_pkg::job_ctl_t    q_ctl,
  input  logic [VALUE_WIDTH-1:0] q_value,
  output logic                   empty,
  input  logic                   pop,
  output ritoa_pkg::res_t        res
);

  localparam int W      = VALUE_WIDTH;
  localparam int CHUNKS = (W + 7) / 8;
  localparam int DW     = CHUNKS * 8;
  localparam int PW     = W + 4;
  localparam int NW     = $clog2(W + 1);
  localparam int AW     = $clog2(W);
  localparam int CW     = $clog2(CHUNKS + 1);
  localparam int OD     = ritoa_pkg::OUT_DEPTH;
  localparam int OPW    = $clog2(OD);
  localparam int OCW    = $clog2(OD + 1);
  localparam int BW     = ritoa_pkg::BASE_W;
  localparam int DGW    = ritoa_pkg::DIGIT_W;

  ritoa_pkg::back_state_t st, st_next;

  logic [DW-1:0]   rem;
  logic [DGW-1:0]  r;
  logic [BW-1:0]   base;
  logic            pad;
  logic            no_dig;
  logic [NW-1:0]   n;
  logic [PW-1:0]   p;
  logic [PW-1:0]   p_mul;
  logic [CW-1:0]   chunk;
  logic [AW-1:0]   idx;
  logic            last_chunk;
  logic [7:0]      div_q;
  logic [DGW-1:0]  div_rem;
  logic            more;

  logic            ram_we;
  logic [DGW-1:0]  ram_rdata;
  logic            issue;
  logic            issue_ok;
  logic            issue_last;

  logic            rd_valid;
  logic            rd_last;
  logic            rd_empty;
  logic [ritoa_pkg::COUNT_W-1:0] rd_count;

  ritoa_pkg::res_t ob [OD];
  ritoa_pkg::res_t push_item;
  logic [OPW-1:0]  owp;
  logic [OPW-1:0]  orp;
  logic [OCW-1:0]  ocnt;
  logic [OCW:0]    used;
  logic            pop_o;

  // eight restoring steps on the top byte of the dividend
  always_comb begin
    logic [DGW:0] t;
    logic [DGW-1:0] rr;
    rr    = r;
    div_q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {rr, rem[DW-8+i]};
      if (t >= {1'b0, base[DGW-1:0]} || base[DGW]) begin
        if (t >= DGW'(0) + {1'b0, base[DGW-1:0]} && !base[DGW]) begin
          t = t - {1'b0, base[DGW-1:0]};
          div_q[i] = 1'b1;
        end else if (base[DGW] && t[DGW]) begin
          t = t - {1'b1, {DGW{1'b0}}};
          div_q[i] = 1'b1;
        end
      end
      rr = t[DGW-1:0];
    end
    div_rem = rr;
  end

  // base^n kept alongside, by shift and add
  always_comb begin
    p_mul = '0;
    for (int i = 0; i < BW; i++) begin
      if (base[i]) begin
        p_mul = p_mul + (PW'(p[W-1:0]) << i);
      end
    end
  end

  assign last_chunk = (chunk == CW'(CHUNKS - 1));
  assign more       = (p[PW-1:W] == '0) && (pad || (rem != '0));
  assign ram_we     = (st == ritoa_pkg::BK_DIV) && last_chunk;

  assign pop_o    = pop && !empty;
  assign used     = {1'b0, ocnt} + (OCW+1)'(rd_valid) - (OCW+1)'(pop_o);
  assign issue_ok = (used < (OCW+1)'(OD));
  assign issue    = (st == ritoa_pkg::BK_EMIT) && issue_ok;
  assign issue_last = no_dig || (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ritoa_pkg::BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    q_pop   = 1'b0;
    case (st)
      ritoa_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          st_next = q_ctl.no_digits ? ritoa_pkg::BK_EMIT : ritoa_pkg::BK_DIV;
        end
      end
      ritoa_pkg::BK_DIV: begin
        if (last_chunk) begin
          st_next = ritoa_pkg::BK_NEXT;
        end
      end
      ritoa_pkg::BK_NEXT: begin
        st_next = more ? ritoa_pkg::BK_DIV : ritoa_pkg::BK_EMIT;
      end
      ritoa_pkg::BK_EMIT: begin
        if (issue && issue_last) begin
          st_next = ritoa_pkg::BK_IDLE;
        end
      end
      default: st_next = ritoa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      ritoa_pkg::BK_IDLE: begin
        if (!q_empty) begin
          rem    <= DW'(q_value);
          base   <= q_ctl.base;
          pad    <= q_ctl.pad_zero;
          no_dig <= q_ctl.no_digits;
          n      <= '0;
          p      <= PW'(1);
          chunk  <= '0;
          r      <= '0;
        end
      end
      ritoa_pkg::BK_DIV: begin
        rem <= DW'({rem, div_q});
        if (last_chunk) begin
          n     <= n + 1'b1;
          p     <= p_mul;
          chunk <= '0;
          r     <= '0;
        end else begin
          chunk <= chunk + 1'b1;
          r     <= div_rem;
        end
      end
      ritoa_pkg::BK_NEXT: begin
        idx <= AW'(n - 1'b1);
      end
      ritoa_pkg::BK_EMIT: begin
        if (issue) begin
          idx <= idx - 1'b1;
        end
      end
      default: ;
    endcase
  end

  ritoa_ram #(
    .WIDTH(DGW),
    .DEPTH(W)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(n[AW-1:0]),
    .wdata(div_rem),
    .re   (issue),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last  <= issue_last;
      rd_empty <= no_dig;
      rd_count <= no_dig ? '0 : ritoa_pkg::COUNT_W'(n);
    end
  end

  always_comb begin
    push_item.digit_char  = rd_empty ? '0 : ritoa_pkg::ascii_of(ram_rdata);
    push_item.is_last     = rd_last;
    push_item.empty_res   = rd_empty;
    push_item.digit_count = rd_count;
  end

  assign empty = (ocnt == '0);
  assign res   = ob[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (rd_valid) begin
        owp <= owp + 1'b1;
      end
      if (pop_o) begin
        orp <= orp + 1'b1;
      end
      if (rd_valid && !pop_o) begin
        ocnt <= ocnt + 1'b1;
      end else if (pop_o && !rd_valid) begin
        ocnt <= ocnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      ob[owp] <= push_item;
    end
  end

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt <= OCW'(OD))
    else $error("output queue over capacity");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rd_valid && (ocnt == OCW'(OD)) |-> pop_o)
    else $error("digit arrived at a full output queue");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rd_valid && rd_empty |-> rd_last && (rd_count == '0))
    else $error("empty conversion not a single final transfer");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (n < NW'(W)))
    else $error("digit buffer write beyond depth");

endmodule

// ----- hw/rtl/radix_integer_to_ascii.sv -----
// Top level of the radix integer to ASCII converter.
// Usage:
//   Requests enter on push/full with req (value, base, pad_zero); a transfer
//   happens when push is high and full is low. Digits leave on empty/pop with
//   res; the oldest digit sits on res while empty is low and is taken when pop
//   is high. Digits come most significant first; is_last marks the final one.
//   A zero value without padding yields one transfer with empty_res set.
// Flow:
//   The front stage registers and classifies a request and hands it to a
//   two-entry job queue, so a new request is taken while the back part works.
//   Each digit comes from the shared long-division unit, which retires eight
//   dividend bits per cycle, followed by a test for the next digit. While the
//   output queue has room, digits are then read back from the digit RAM at
//   one per cycle.
// Reset clears all queues and returns the back part to idle; the digit RAM
//   needs no clearing. If the receiver stops popping, the two-entry output
//   queue fills, digit readout pauses, and later requests wait in the queue.
`timescale 1ns / 1ps

module radix_integer_to_ascii #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  ritoa_pkg::req_t req,
  output logic            empty,
  input  logic            pop,
  output ritoa_pkg::res_t res
);

  localparam int JOB_W = $bits(ritoa_pkg::job_ctl_t) + VALUE_WIDTH;

  logic                     fq_push;
  logic                     fq_full;
  ritoa_pkg::job_ctl_t      f_ctl;
  logic [VALUE_WIDTH-1:0]   f_value;
  logic                     q_pop;
  logic                     q_empty;
  logic [JOB_W-1:0]         q_rdata;
  ritoa_pkg::job_ctl_t      q_ctl;
  logic [VALUE_WIDTH-1:0]   q_value;

  ritoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req      (req),
    .q_push   (fq_push),
    .q_full   (fq_full),
    .job_ctl  (f_ctl),
    .job_value(f_value)
  );

  ritoa_queue #(
    .WIDTH(JOB_W),
    .DEPTH(ritoa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (fq_push),
    .full (fq_full),
    .wdata({f_ctl, f_value}),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  assign q_ctl   = q_rdata[JOB_W-1:VALUE_WIDTH];
  assign q_value = q_rdata[VALUE_WIDTH-1:0];

  ritoa_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .q_ctl  (q_ctl),
    .q_value(q_value),
    .empty  (empty),
    .pop    (pop),
    .res    (res)
  );

endmodule

// ----- sim/ritoa_digit_checker.sv -----
// Checker for the radix converter: predicts digit transfers per request and compares them.
`timescale 1ns / 1ps

module ritoa_digit_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            full,
  input  ritoa_pkg::req_t req,
  input  logic            empty,
  input  logic            pop,
  input  ritoa_pkg::res_t res,
  output int              fail_count,
  output int              pending_digits
);

  ritoa_pkg::res_t digit_queue[$];

  function automatic logic [ritoa_pkg::CHAR_W-1:0] digit_to_char(
    input logic [ritoa_pkg::DIGIT_W-1:0] d);
    logic [ritoa_pkg::CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = 7'h30 + 7'(d);
    end else begin
      c = 7'h61 + 7'(d) - 7'd10;
    end
    return c;
  endfunction

  // Repeated division, least significant digit first, then queued most significant first.
  function automatic void expand_digits(input ritoa_pkg::req_t r);
    logic [31:0]                   rem;
    logic [31:0]                   span;
    logic [31:0]                   radix;
    logic [ritoa_pkg::DIGIT_W-1:0] digs[32];
    int                            n;
    ritoa_pkg::res_t               item;
    radix = 32'(r.base);
    if (radix < 32'd2) radix = 32'd2;
    if (radix > 32'd16) radix = 32'd16;
    rem  = r.value;
    span = '1;
    n    = 0;
    while (span != 0 && n < 32) begin
      if (!r.pad_zero && rem == 0) break;
      digs[n] = ritoa_pkg::DIGIT_W'(rem % radix);
      n++;
      rem  = rem / radix;
      span = span / radix;
    end
    if (n == 0) begin
      item.digit_char  = '0;
      item.is_last     = 1'b1;
      item.empty_res   = 1'b1;
      item.digit_count = '0;
      digit_queue.push_back(item);
    end else begin
      for (int k = 0; k < n; k++) begin
        item.digit_char  = digit_to_char(digs[n - 1 - k]);
        item.is_last     = (k == n - 1);
        item.empty_res   = 1'b0;
        item.digit_count = ritoa_pkg::COUNT_W'(n);
        digit_queue.push_back(item);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    ritoa_pkg::res_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (digit_queue.size() == 0) begin
          $error("digit transfer with nothing expected: %0h", res);
          fail_count++;
        end else begin
          want = digit_queue.pop_front();
          check_field("digit_char", want.digit_char, res.digit_char);
          check_field("is_last", want.is_last, res.is_last);
          check_field("empty_res", want.empty_res, res.empty_res);
          check_field("digit_count", want.digit_count, res.digit_count);
        end
      end
      if (push && !full) expand_digits(req);
    end
    pending_digits = digit_queue.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the radix converter: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int PHASE_ITEMS  = 72;
  localparam int DRAIN_CYCLES = 200;

  logic            clk = 1'b0;
  logic            rst;
  logic            push;
  logic            full;
  ritoa_pkg::req_t req;
  logic            empty;
  logic            pop;
  ritoa_pkg::res_t res;

  int fail_count;
  int pending_digits;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  radix_integer_to_ascii i_dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .req  (req),
    .empty(empty),
    .pop  (pop),
    .res  (res)
  );

  ritoa_digit_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req           (req),
    .empty         (empty),
    .pop           (pop),
    .res           (res),
    .fail_count    (fail_count),
    .pending_digits(pending_digits)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic ritoa_pkg::req_t make_req(input logic [31:0] v, input logic [4:0] b,
                                               input logic p);
    ritoa_pkg::req_t r;
    r.value    = v;
    r.base     = b;
    r.pad_zero = p;
    return r;
  endfunction

  function automatic ritoa_pkg::req_t random_request();
    ritoa_pkg::req_t r;
    int              sel;
    sel = $urandom_range(0, 9);
    r.value = $urandom();
    case (sel)
      0:       r.value = '0;
      1, 2, 3: r.value = 32'($urandom_range(0, 255));
      4:       r.value = r.value >> $urandom_range(0, 31);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      r.base = 5'($urandom_range(0, 31));
    end else begin
      r.base = 5'($urandom_range(2, 16));
    end
    r.pad_zero = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input ritoa_pkg::req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req  <= r;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (pending_digits != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    req = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, all-ones, saturated bases, letter digits
    send_request(make_req(32'h0, 5'd10, 1'b0));
    send_request(make_req(32'h0, 5'd2, 1'b1));
    send_request(make_req(32'h0, 5'd16, 1'b1));
    send_request(make_req(32'hFFFF_FFFF, 5'd2, 1'b0));
    send_request(make_req(32'hFFFF_FFFF, 5'd2, 1'b1));
    send_request(make_req(32'hFFFF_FFFF, 5'd16, 1'b0));
    send_request(make_req(32'hFFFF_FFFF, 5'd16, 1'b1));
    send_request(make_req(32'hFFFF_FFFF, 5'd10, 1'b0));
    send_request(make_req(32'h0000_0001, 5'd10, 1'b0));
    send_request(make_req(32'h0000_0001, 5'd10, 1'b1));
    send_request(make_req(32'hDEAD_BEEF, 5'd16, 1'b0));
    send_request(make_req(32'h0123_4567, 5'd8, 1'b1));
    send_request(make_req(32'h89AB_CDEF, 5'd3, 1'b0));
    send_request(make_req(32'h0000_00FF, 5'd0, 1'b0));
    send_request(make_req(32'h0000_00FF, 5'd1, 1'b1));
    send_request(make_req(32'h0000_00FF, 5'd17, 1'b0));
    send_request(make_req(32'h0000_00FF, 5'd31, 1'b1));
    send_request(make_req(32'h8000_0000, 5'd7, 1'b0));
    send_request(make_req(32'h7FFF_FFFF, 5'd15, 1'b1));
    send_request(make_req(32'h0000_0000, 5'd31, 1'b0));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_digits == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
